/* hdl/vebb_pkg.sv */
// ----------------------------------------------------------------------------
// vebb_pkg
// Shared constants, state encoding and controller/datapath bundles for the
// encoder bus-bridge register window.
// ----------------------------------------------------------------------------
package vebb_pkg;

	// Window placement and store sizes
	localparam logic [31:0] BASE_ADDR     = 32'h1A00_0000;
	localparam logic [31:0] WINDOW_SIZE   = 32'd256;
	localparam int          NUM_BRIDGE    = 32;
	localparam int          ENC_REG_COUNT = 256;
	localparam int          BW_IDX_W      = $clog2(NUM_BRIDGE);
	localparam int          ENC_IDX_W     = $clog2(ENC_REG_COUNT);

	// Bridge word offsets with special meaning
	localparam logic [7:0] OFF_COMMAND = 8'h00;
	localparam logic [7:0] OFF_STATUS  = 8'h06;
	localparam logic [7:0] OFF_POWER   = 8'h0A;
	localparam logic [BW_IDX_W-1:0] BW_MODE   = 5'h02;
	localparam logic [BW_IDX_W-1:0] BW_STATUS = 5'h06;
	localparam logic [BW_IDX_W-1:0] BW_POWER  = 5'h0A;
	localparam logic [BW_IDX_W-1:0] BW_INDEX  = 5'h10;

	// Mode codes
	localparam logic [15:0] MODE_ERR_A = 16'h004F;
	localparam logic [15:0] MODE_ERR_B = 16'h0041;
	localparam logic [15:0] MODE_COPY  = 16'h0043;
	localparam logic [15:0] MODE_FILL  = 16'h0042;

	// Reset contents
	localparam logic [15:0]          BW_POWER_RST = 16'h0001;
	localparam logic [ENC_IDX_W-1:0] ENC_RST_IDX  = 8'h7E;
	localparam logic [15:0]          ENC_RST_VAL  = 16'h001C;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_EXEC,
		ST_COPY,
		ST_FILL,
		ST_DONE
	} vebb_state_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic decode;
		logic exec;
		logic copy;
		logic fill;
		logic load_out;
	} vebb_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic act_copy;
		logic act_fill;
		logic fill_last;
	} vebb_sts_t;

endpackage

/* hdl/vebb_ctrl.sv */
// ----------------------------------------------------------------------------
// vebb_ctrl
// Request sequencer: steps each request through decode, execute and the
// optional copy or fill phase, and owns the result valid flag.
// ----------------------------------------------------------------------------
module vebb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  vebb_pkg::vebb_sts_t sts,
	output vebb_pkg::vebb_cmd_t cmd
);
	import vebb_pkg::*;

	vebb_state_t state_q, state_nxt;
	logic        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_DECODE;
			end
			ST_DECODE: state_nxt = ST_EXEC;
			ST_EXEC: begin
				if (sts.act_copy)      state_nxt = ST_COPY;
				else if (sts.act_fill) state_nxt = ST_FILL;
				else                   state_nxt = ST_DONE;
			end
			ST_COPY: state_nxt = ST_DONE;
			ST_FILL: begin
				if (sts.fill_last) state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
			end
			ST_DECODE: cmd.decode = 1'b1;
			ST_EXEC:   cmd.exec   = 1'b1;
			ST_COPY:   cmd.copy   = 1'b1;
			ST_FILL:   cmd.fill   = 1'b1;
			ST_DONE:   cmd.load_out = !out_valid_q || !out_stall;
			default: begin
				cmd = '0;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

/* hdl/vebb_dp.sv */
// ----------------------------------------------------------------------------
// vebb_dp
// Datapath: request registers, window decode, bridge word file, encoder
// register memory, status flags and the result register.
// ----------------------------------------------------------------------------
module vebb_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  vebb_pkg::vebb_cmd_t cmd,
	output vebb_pkg::vebb_sts_t sts,
	input  logic              req_cmd,
	input  logic [31:0]       req_addr,
	input  logic [15:0]       req_data,
	output logic              hit,
	output logic [15:0]       read_data
);
	import vebb_pkg::*;

	// Request
	logic        req_cmd_q;
	logic [31:0] req_addr_q;
	logic [15:0] req_data_q;

	// Decode stage
	logic        hit_s1;
	logic        stat_rd_s1;
	logic [7:0]  off_s1;
	logic [31:0] off_full;

	// Bridge words and flags
	logic [15:0]                bw_q [NUM_BRIDGE];
	logic                       busy_q;
	logic                       err_q;
	logic [ENC_IDX_W-1:0]       sel_q;
	logic [3:0]                 fill_idx_q;
	logic [15:0]                res_rd_q;
	logic                       out_hit_q;
	logic [15:0]                out_rd_q;

	// Encoder register memory
	logic [15:0]          enc_mem [ENC_REG_COUNT];
	logic [ENC_REG_COUNT-1:0] enc_vld_q;
	logic [15:0]          enc_rd_q;
	logic                 enc_rd_vld_q;
	logic                 enc_rd_def_q;
	logic [15:0]          enc_val;

	// Bridge word ports
	logic [BW_IDX_W-1:0] bw_ra;
	logic [15:0]         bw_rd;
	logic                bw_we;
	logic [BW_IDX_W-1:0] bw_wa;
	logic [15:0]         bw_wd;

	logic [3:0]  cnt_n;
	logic        is_wr_cmd;
	logic        start_bit;
	logic        mode_err;
	logic        mode_copy;
	logic        mode_fill;
	logic        stat_inc;

	assign off_full  = req_addr_q - BASE_ADDR;
	assign cnt_n     = req_data_q[3:0];
	assign start_bit = req_data_q[7];
	assign is_wr_cmd = hit_s1 && req_cmd_q && (off_s1 == OFF_COMMAND);
	assign mode_err  = (bw_q[BW_MODE] == MODE_ERR_A) || (bw_q[BW_MODE] == MODE_ERR_B);
	assign mode_copy = bw_q[BW_MODE] == MODE_COPY;
	assign mode_fill = bw_q[BW_MODE] == MODE_FILL;
	assign stat_inc  = (bw_q[BW_STATUS] < 16'd3) && busy_q;

	assign sts.act_copy  = is_wr_cmd && start_bit && mode_copy && (cnt_n >= 4'd2);
	assign sts.act_fill  = is_wr_cmd && start_bit && mode_fill && (cnt_n != 4'd0);
	assign sts.fill_last = fill_idx_q == (cnt_n - 4'd1);

	assign bw_ra = cmd.copy ? {1'b1, cnt_n} : req_addr_q[BW_IDX_W-1:0];
	assign bw_rd = bw_q[bw_ra];

	assign enc_val = enc_rd_vld_q ? enc_rd_q : (enc_rd_def_q ? ENC_RST_VAL : 16'h0000);

	// Bridge word write port
	always_comb begin
		bw_we = 1'b0;
		bw_wa = off_s1[BW_IDX_W-1:0];
		bw_wd = req_data_q;
		if (cmd.fill) begin
			bw_we = 1'b1;
			bw_wa = {1'b1, fill_idx_q};
			bw_wd = enc_val;
		end else if (cmd.exec && hit_s1) begin
			if (!req_cmd_q) begin
				bw_we = stat_rd_s1 && stat_inc;
				bw_wa = BW_STATUS;
				bw_wd = bw_q[BW_STATUS] + 16'd1;
			end else if (off_s1 == OFF_STATUS) begin
				bw_we = 1'b1;
				bw_wa = BW_STATUS;
				bw_wd = bw_q[BW_STATUS] & 16'hFFFC;
			end else begin
				bw_we = off_s1 < 8'(NUM_BRIDGE);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_cmd_q  <= req_cmd;
			req_addr_q <= req_addr;
			req_data_q <= req_data;
		end
		if (cmd.decode) begin
			hit_s1     <= (req_addr_q >= BASE_ADDR) && (off_full < WINDOW_SIZE);
			off_s1     <= off_full[7:0];
			stat_rd_s1 <= !req_cmd_q && (off_full == 32'(OFF_STATUS));
		end
		if (cmd.exec) begin
			if (!hit_s1 || req_cmd_q) begin
				res_rd_q <= 16'h0000;
			end else if (stat_rd_s1) begin
				res_rd_q <= {14'd0, bw_q[BW_STATUS][1], err_q};
			end else begin
				res_rd_q <= bw_rd;
			end
		end
		if (cmd.load_out) begin
			out_hit_q <= hit_s1;
			out_rd_q  <= res_rd_q;
		end
		// Encoder memory: read every cycle, write on copy
		enc_rd_q     <= enc_mem[sel_q];
		enc_rd_vld_q <= enc_vld_q[sel_q];
		enc_rd_def_q <= sel_q == ENC_RST_IDX;
		if (cmd.copy) begin
			enc_mem[sel_q] <= bw_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BRIDGE; i++) begin
				bw_q[i] <= 16'h0000;
			end
			bw_q[BW_POWER] <= BW_POWER_RST;
			enc_vld_q  <= '0;
			busy_q     <= 1'b0;
			err_q      <= 1'b0;
			sel_q      <= '0;
			fill_idx_q <= '0;
		end else begin
			if (bw_we) begin
				bw_q[bw_wa] <= bw_wd;
			end
			if (cmd.copy) begin
				enc_vld_q[sel_q] <= 1'b1;
			end
			if (cmd.exec) begin
				fill_idx_q <= '0;
			end else if (cmd.fill) begin
				fill_idx_q <= fill_idx_q + 4'd1;
			end
			if (cmd.exec && hit_s1) begin
				if (stat_rd_s1 && !stat_inc) begin
					busy_q <= 1'b0;
				end
				if (is_wr_cmd) begin
					if (mode_err) begin
						err_q <= 1'b1;
					end else if (start_bit && (mode_copy || mode_fill)) begin
						busy_q <= 1'b1;
						err_q  <= 1'b0;
						if (mode_copy) begin
							sel_q <= bw_q[BW_INDEX][ENC_IDX_W-1:0];
						end
					end
				end else if (req_cmd_q && (off_s1 == OFF_POWER)) begin
					err_q <= req_data_q == 16'h0000;
				end
			end
		end
	end

	assign hit       = out_hit_q;
	assign read_data = out_rd_q;

endmodule

/* hdl/video_encoder_bus_bridge_regs.sv */
// Sequence: a plain access is accepted, decoded, executed and then loaded into the result register;
// a copy command adds a copy phase and a fill command adds one fill step per filled bridge word (up to 15).
// Throughput: one request at a time, set by the sequencer; a fill writes its bridge words
// through the single write port of the bridge word file.
// Reset: arst_n clears the bridge words (power word to 1), the encoder register valid bits,
// the busy, error and selection state, and empties the result register.
// ----------------------------------------------------------------------------
// video_encoder_bus_bridge_regs
// Encoder bus-bridge register window: decodes 16-bit bus requests against the
// window, serves bridge word reads and status polls, and runs the copy and
// fill commands between the bridge words and the encoder registers.
// ----------------------------------------------------------------------------
module video_encoder_bus_bridge_regs (
	input  logic        clk,
	input  logic        arst_n,
	// Request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [31:0] bus_addr,
	input  logic [15:0] write_data,
	// Result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        hit,
	output logic [15:0] read_data
);
	import vebb_pkg::*;

	vebb_cmd_t dp_cmd;
	vebb_sts_t dp_sts;

	// Sequencer: accept one request, hold off the next until its result is
	// handed to the result register. A finished result may wait there while
	// the next request is already being worked on.
	vebb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (dp_sts),
		.cmd       (dp_cmd)
	);

	// Datapath: decode the window, update the bridge words and flags, and
	// drive the copy and fill transfers with the encoder register memory.
	vebb_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (dp_cmd),
		.sts       (dp_sts),
		.req_cmd   (cmd),
		.req_addr  (bus_addr),
		.req_data  (write_data),
		.hit       (hit),
		.read_data (read_data)
	);

endmodule

/* hdl/vebb_checker.sv */
// ----------------------------------------------------------------------------
// vebb_checker
// Port-level checks for the encoder bus-bridge register window.
// ----------------------------------------------------------------------------
module vebb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        hit,
	input logic [15:0] read_data
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hit) && $stable(read_data))
		else $error("stalled result changed");

	// A miss returns zero data
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> read_data == 16'h0000)
		else $error("miss with non-zero data");

	// Requests are held off through decode and execute after acceptance
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall ##1 in_stall)
		else $error("request accepted too early");

	// A result only appears while a request was in flight
	a_result_from_request: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without request");

endmodule

bind video_encoder_bus_bridge_regs vebb_checker u_vebb_checker (.*);
